// ===== rtl/httd_pkg.sv =====
// ----------------------------------------------------------------------------
// httd_pkg: shared types and constants for the Huffman tree table decoder
// Table geometry, field widths, operation codes, the control/status bundles
// between controller and datapath, and small table-walk helpers.
// ----------------------------------------------------------------------------
package httd_pkg;

  // Table geometry (power of two, 4 to 512 entries)
  localparam int TREE_ENTRIES = 512;
  localparam int IDX_W        = $clog2(TREE_ENTRIES);

  // Field widths
  localparam int OP_W      = 2;
  localparam int VALUE_W   = 9;
  localparam int SYM_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 24;
  localparam int BIT_CNT_W = $clog2(BYTE_W);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Operation codes carried by the operation field
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // Root node of the code tree
  localparam value_t ROOT_NODE = value_t'(1);

  // Controller to datapath
  typedef struct packed {
    logic in_ready;   // input channel open
    logic start;      // begin a byte walk, issue the first table read
    logic step;       // consume one bit, issue the next table read
    logic push;       // move the pending symbol to the output register
    logic push_last;  // flag the pushed symbol as the last of its byte
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_decode;  // offered request is a data byte
    logic halted;     // limit reached, data bytes give nothing
    logic leaf;       // current table entry is a leaf
    logic limit_hit;  // that leaf would be the final symbol
    logic bit_last;   // current bit is the byte's LSB
    logic pend_valid; // a symbol waits in the pending register
    logic out_free;   // output register can take a symbol this cycle
  } ctrl_status_t;

  // Next table index: node * 2 + bit, wrapped to the table size
  function automatic idx_t tree_addr(input value_t node, input logic b);
    logic [VALUE_W:0] wide;
    wide = {node, b};
    return idx_t'(wide);
  endfunction

  // Zero or negative entries are leaves
  function automatic logic is_leaf(input value_t raw);
    return (raw == '0) || raw[VALUE_W-1];
  endfunction

  // Leaf symbol is the negated entry, low byte only
  function automatic sym_t leaf_symbol(input value_t raw);
    value_t neg;
    neg = value_t'('0) - raw;
    return neg[SYM_W-1:0];
  endfunction

endpackage

// ===== rtl/httd_in_if.sv =====
// ----------------------------------------------------------------------------
// httd_in_if: request channel of the tree table decoder
// Valid/ready handshake carrying operation, table write fields and data byte.
// ----------------------------------------------------------------------------
interface httd_in_if;
  import httd_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [VALUE_W-1:0]  tree_index;
  logic signed [VALUE_W-1:0] tree_value;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, operation, tree_index, tree_value, data_byte,
                  input ready);
  modport sink   (input valid, operation, tree_index, tree_value, data_byte,
                  output ready);
endinterface

// ===== rtl/httd_out_if.sv =====
// ----------------------------------------------------------------------------
// httd_out_if: symbol channel of the tree table decoder
// Valid/ready handshake carrying one decoded symbol and its flags.
// ----------------------------------------------------------------------------
interface httd_out_if;
  import httd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             done_res;

  modport source (output valid, symbol, last, done_res, input ready);
  modport sink   (input valid, symbol, last, done_res, output ready);
endinterface

// ===== rtl/huffman_tree_table_decoder_unit.sv =====
// A table write or restart request is taken while the controller is idle. A
// data byte walks one bit a cycle through the synchronous table read, held
// while a finished symbol cannot leave; the request channel stays closed
// until the walk and its flush end (sooner at the symbol limit). Symbols pass
// the pending and output registers. Reset clears node to 1, count, finished
// flag and limit; the tree table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// huffman_tree_table_decoder_unit: table driven bit-serial Huffman decoder
// Controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
module huffman_tree_table_decoder_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [httd_pkg::COUNT_W-1:0] cfg_wr_data,
  httd_in_if.sink                      item,
  httd_out_if.source                   result
);
  import httd_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t sts;

  httd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  httd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .result      (result),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== rtl/httd_ctrl.sv =====
// ----------------------------------------------------------------------------
// httd_ctrl: sequencing controller of the tree table decoder
// Opens the request channel when idle, steps the bit walk one bit a cycle and
// holds the walk while a finished symbol cannot leave.
// ----------------------------------------------------------------------------
module httd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  httd_pkg::ctrl_status_t sts,
  output httd_pkg::ctrl_cmd_t    cmd
);
  import httd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid && sts.in_decode && !sts.halted) begin
          cmd.start  = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        // a new leaf displaces the pending symbol, which needs the output
        if (!(sts.leaf && sts.pend_valid && !sts.out_free)) begin
          cmd.step = 1'b1;
          cmd.push = sts.leaf && sts.pend_valid;
          if ((sts.leaf && sts.limit_hit) || sts.bit_last) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/httd_datapath.sv =====
// ----------------------------------------------------------------------------
// httd_datapath: table memory, walk registers and output stage
// Holds the tree table, current node, symbol count, limit, the byte shifter,
// one pending symbol and the output register.
// ----------------------------------------------------------------------------
module httd_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [httd_pkg::COUNT_W-1:0] cfg_wr_data,
  httd_in_if.sink                item,
  httd_out_if.source             result,
  input  httd_pkg::ctrl_cmd_t    cmd,
  output httd_pkg::ctrl_status_t sts
);
  import httd_pkg::*;

  value_t tree_mem [TREE_ENTRIES];
  value_t rd_data;
  idx_t   rd_addr;
  logic   rd_en;

  value_t node;
  count_t count;
  count_t limit;
  logic   finished;
  byte_t  shift;
  logic [BIT_CNT_W-1:0] bit_cnt;

  logic   pend_valid;
  sym_t   pend_sym;
  logic   pend_done;

  logic   out_valid;
  sym_t   out_sym;
  logic   out_last;
  logic   out_done;

  logic   accept;
  logic   leaf;
  count_t count_inc;
  logic   limit_hit;
  value_t node_after;

  assign accept     = item.valid && cmd.in_ready;
  assign leaf       = is_leaf(rd_data);
  assign count_inc  = count + count_t'(1);
  assign limit_hit  = (count_inc == limit);
  assign node_after = leaf ? ROOT_NODE : rd_data;

  // Table read address: first bit from the request, later bits from the shifter
  assign rd_en   = cmd.start || cmd.step;
  assign rd_addr = cmd.start ? tree_addr(node, item.data_byte[BYTE_W-1])
                             : tree_addr(node_after, shift[BYTE_W-2]);

  // Tree table memory
  always_ff @(posedge clk) begin
    if (accept && (item.operation == OP_LOAD)) begin
      tree_mem[idx_t'(item.tree_index)] <= value_t'(item.tree_value);
    end
    if (rd_en) begin
      rd_data <= tree_mem[rd_addr];
    end
  end

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // Walk state: node, count, finished flag
  always_ff @(posedge clk) begin
    if (rst) begin
      node     <= ROOT_NODE;
      count    <= '0;
      finished <= 1'b0;
    end else if (accept && (item.operation == OP_RESTART)) begin
      node     <= ROOT_NODE;
      count    <= '0;
      finished <= 1'b0;
    end else if (cmd.step) begin
      node <= node_after;
      if (leaf) begin
        count    <= count_inc;
        finished <= limit_hit;
      end
    end
  end

  // Byte shifter and bit counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      shift   <= item.data_byte;
      bit_cnt <= '0;
    end else if (cmd.step) begin
      shift   <= {shift[BYTE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
  end

  // Pending symbol: held until the next leaf or the end of the byte says
  // whether it is the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && leaf) begin
      pend_valid <= 1'b1;
    end else if (cmd.push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && leaf) begin
      pend_sym  <= leaf_symbol(rd_data);
      pend_done <= limit_hit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_sym  <= pend_sym;
      out_last <= cmd.push_last;
      out_done <= pend_done;
    end
  end

  assign item.ready      = cmd.in_ready;
  assign result.valid    = out_valid;
  assign result.symbol   = out_sym;
  assign result.last     = out_last;
  assign result.done_res = out_done;

  // Status to the controller
  always_comb begin
    sts            = '0;
    sts.in_valid   = item.valid;
    sts.in_decode  = (item.operation == OP_DECODE);
    sts.halted     = finished || (count >= limit);
    sts.leaf       = leaf;
    sts.limit_hit  = limit_hit;
    sts.bit_last   = (bit_cnt == BIT_CNT_W'(BYTE_W - 1));
    sts.pend_valid = pend_valid;
    sts.out_free   = !out_valid || result.ready;
  end

endmodule

// ===== sim/tb_huffman_tree_table_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_table_decoder_unit: self-checking bench for the tree decoder
// A stimulus queue is filled phase by phase, with one symbol limit per phase.
// A clocked driver feeds requests on the falling edge, and a clocked monitor
// tracks the table, the tree walk and the count. Every decoded symbol is
// checked against the oldest predicted one. Table writes are kept closed
// under the walk, so every entry that a walk can reach has been written.
// ----------------------------------------------------------------------------
module tb_huffman_tree_table_decoder_unit;
  import httd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Idle modes, one per phase
  localparam int MODE_STEADY  = 0;
  localparam int MODE_SRC_GAP = 1;
  localparam int MODE_SNK_GAP = 2;
  localparam int MODE_BOTH    = 3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] index;
    value_t             value;
    byte_t              data;
  } request_t;

  typedef struct packed {
    sym_t symbol;
    logic last;
    logic done_res;
  } symbol_out_t;

  logic         clk;
  logic         rst;
  logic         cfg_wr_en;
  count_t       cfg_wr_data;

  httd_in_if  req_ch();
  httd_out_if sym_ch();

  huffman_tree_table_decoder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (req_ch),
    .result      (sym_ch)
  );

  // Stimulus side
  request_t    request_q[$];
  int unsigned requests_open;
  bit          entry_loaded [TREE_ENTRIES];
  int          idle_mode;
  logic        req_taken;

  // Decoder shadow state, tracked at each accepted request
  value_t      tree_shadow [TREE_ENTRIES];
  value_t      walk_node     = value_t'(1);
  count_t      emitted_count = '0;
  logic        walk_finished = 1'b0;
  count_t      limit_q       = '0;
  symbol_out_t expected_syms[$];
  int unsigned mismatches    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[huffman_tree_table_decoder_unit] ERROR");
    $finish;
  end

  function automatic logic sender_idle();
    case (idle_mode)
      MODE_SRC_GAP: return $urandom_range(0, 99) < 85;
      MODE_BOTH:    return $urandom_range(0, 99) < 7;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      MODE_SNK_GAP: return $urandom_range(0, 99) < 85;
      MODE_BOTH:    return $urandom_range(0, 99) < 7;
      default:      return 1'b0;
    endcase
  endfunction

  // Leaf entry: symbol 0..255, or -256 which masks to symbol 0
  function automatic value_t random_leaf();
    int n;
    n = $urandom_range(0, 256);
    return value_t'(-n);
  endfunction

  function automatic value_t random_entry();
    if ($urandom_range(0, 1) == 0) return random_leaf();
    return value_t'($urandom_range(1, 255));
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] index,
                               input value_t value, input byte_t data);
    request_q.push_back('{op, index, value, data});
    requests_open++;
  endtask

  // Table write; an inner node first gets leaves in any child slot not yet loaded
  task automatic queue_table_write(input idx_t slot, input value_t value);
    idx_t child;
    if (value != '0 && !value[VALUE_W-1]) begin
      child = idx_t'((int'(value) * 2) % TREE_ENTRIES);
      for (int k = 0; k < 2; k++) begin
        if (!entry_loaded[child]) begin
          queue_request(OP_LOAD, child, random_leaf(), byte_t'($urandom));
          entry_loaded[child] = 1'b1;
        end
        child = child + idx_t'(1);
      end
    end
    queue_request(OP_LOAD, slot, value, byte_t'($urandom));
    entry_loaded[slot] = 1'b1;
  endtask

  task automatic queue_byte(input byte_t data);
    queue_request(OP_DECODE, 9'($urandom), value_t'($urandom), data);
  endtask

  task automatic queue_restart();
    queue_request(OP_RESTART, 9'($urandom), value_t'($urandom), byte_t'($urandom));
  endtask

  // Wait for all requests and symbols, then let a byte walk run out
  task automatic wait_idle();
    while (requests_open != 0 || expected_syms.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_limit(input count_t limit);
    cfg_wr_data <= limit;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Walk one byte MSB first and queue the symbols it yields
  task automatic walk_byte(input byte_t data);
    idx_t        slot;
    value_t      raw;
    symbol_out_t held;
    logic        have_held;
    have_held = 1'b0;
    if (walk_finished || emitted_count >= limit_q) return;
    for (int pos = 7; pos >= 0; pos--) begin
      slot = idx_t'(((int'(walk_node) * 2) + int'(data[pos])) % TREE_ENTRIES);
      raw  = tree_shadow[slot];
      if (raw == '0 || raw[VALUE_W-1]) begin
        if (have_held) expected_syms.push_back(held);
        emitted_count = emitted_count + count_t'(1);
        walk_node     = value_t'(1);
        held.symbol   = sym_t'(10'h200 - {1'b0, raw});
        held.last     = 1'b0;
        held.done_res = (emitted_count == limit_q);
        have_held     = 1'b1;
        if (emitted_count == limit_q) begin
          walk_finished = 1'b1;
          break;
        end
      end else begin
        walk_node = raw;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_syms.push_back(held);
    end
  endtask

  // Monitor: register writes, symbol checks and request tracking
  always @(posedge clk) begin
    symbol_out_t want;
    symbol_out_t got;
    req_taken = 1'b0;
    if (!rst) begin
      if (cfg_wr_en) limit_q = cfg_wr_data;
      if (sym_ch.valid && sym_ch.ready) begin
        got = '{sym_ch.symbol, sym_ch.last, sym_ch.done_res};
        if (expected_syms.size() == 0) begin
          $display("%0t: mismatch exp none got sym=%0d last=%0b done=%0b",
                   $time, got.symbol, got.last, got.done_res);
          mismatches++;
        end else begin
          want = expected_syms.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp sym=%0d last=%0b done=%0b got sym=%0d last=%0b done=%0b",
                     $time, want.symbol, want.last, want.done_res,
                     got.symbol, got.last, got.done_res);
            mismatches++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        requests_open--;
        case (req_ch.operation)
          OP_LOAD:
            tree_shadow[int'(req_ch.tree_index) % TREE_ENTRIES] = value_t'(req_ch.tree_value);
          OP_DECODE:
            walk_byte(req_ch.data_byte);
          OP_RESTART: begin
            walk_node     = value_t'(1);
            emitted_count = '0;
            walk_finished = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Driver: new request once the last one is taken, random ready on the symbols
  always @(negedge clk) begin
    request_t nxt;
    if (!rst) begin
      if (!req_ch.valid || req_taken) begin
        if (request_q.size() != 0 && !sender_idle()) begin
          nxt = request_q.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.operation  <= nxt.op;
          req_ch.tree_index <= nxt.index;
          req_ch.tree_value <= nxt.value;
          req_ch.data_byte  <= nxt.data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      sym_ch.ready <= !receiver_stall();
    end
  end

  // Stimulus: directed phases, then random phases over idle modes and limits
  initial begin
    count_t limit;
    int     counted;
    int     pick;
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_LOAD;
    req_ch.tree_index = '0;
    req_ch.tree_value = '0;
    req_ch.data_byte  = '0;
    sym_ch.ready      = 1'b0;
    idle_mode         = MODE_STEADY;
    requests_open     = 0;
    req_taken         = 1'b0;
    for (int i = 0; i < TREE_ENTRIES; i++) begin
      entry_loaded[i] = 1'b0;
      tree_shadow[i]  = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Small fixed tree: root children 2/3, node 2 -> 4/5, node 255 -> 510/511
    set_limit(count_t'(24'hFFFFFF));
    queue_table_write(idx_t'(0), value_t'(0));
    queue_table_write(idx_t'(1), value_t'(0));
    queue_table_write(idx_t'(3), value_t'(-255));
    queue_table_write(idx_t'(4), value_t'(0));
    queue_table_write(idx_t'(510), value_t'(-256));
    queue_table_write(idx_t'(511), value_t'(-1));
    queue_table_write(idx_t'(5), value_t'(255));
    queue_table_write(idx_t'(2), value_t'(2));
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h6D);  // ends mid-walk, next byte resumes from node 255
    queue_byte(8'h5A);
    queue_request(OP_UNUSED, 9'h1FF, value_t'(9'h1FF), 8'hFF);
    queue_byte(8'hA5);
    queue_restart();
    queue_byte(8'h6D);
    wait_idle();

    // Zero limit decodes nothing
    set_limit('0);
    queue_restart();
    queue_byte(8'hFF);
    queue_byte(8'h00);
    wait_idle();

    // Limit of one: single symbol, then silent until a restart
    set_limit(count_t'(1));
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_restart();
    queue_byte(8'hFF);
    wait_idle();

    // Raised limit stays halted without a restart; stop mid-byte after that
    set_limit(count_t'(3));
    queue_byte(8'hFF);
    queue_restart();
    queue_byte(8'hFF);
    queue_byte(8'h00);
    wait_idle();

    // Random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 2, 5, 7: limit = count_t'(24'hFFFFFF);
        1, 6:       limit = count_t'($urandom_range(5, 30));
        3:          limit = count_t'($urandom_range(1, 4));
        default:    limit = count_t'($urandom_range(40, 120));
      endcase
      idle_mode = ph % 4;
      set_limit(limit);
      queue_restart();
      counted = 0;
      while (counted < 12) begin
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
          queue_table_write(idx_t'($urandom_range(0, TREE_ENTRIES - 1)), random_entry());
        end else if (pick < 38) begin
          queue_restart();
        end else if (pick < 41) begin
          queue_request(OP_UNUSED, 9'($urandom), value_t'($urandom), byte_t'($urandom));
          continue;
        end else begin
          queue_byte(byte_t'($urandom));
        end
        counted++;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[huffman_tree_table_decoder_unit] OK");
    end else begin
      $display("[huffman_tree_table_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
